### hw/rtl/ctb_pkg.sv
// shared types, widths and codes of the countdown timer bank
`default_nettype none

package ctb_pkg;

  // default sizes of the timer table
  localparam int SLOTS_DEF       = 16;
  localparam int KEY_WIDTH_DEF   = 16;
  localparam int COUNT_WIDTH_DEF = 32;

  // item field widths
  localparam int REQ_W        = 3;
  localparam int KEY_PORT_W   = 16;
  localparam int VALUE_PORT_W = 32;
  localparam int STATUS_W     = 3;
  localparam int ACTIVE_W     = 5;
  localparam int MS_W         = 10;
  localparam int SEC_W        = 6;
  localparam int MIN_W        = 6;
  localparam int HOUR_W       = 5;
  localparam int DAY_W        = 16;

  // time-of-day rollover points
  localparam int MS_PER_SEC   = 1000;
  localparam int SEC_PER_MIN  = 60;
  localparam int MIN_PER_HOUR = 60;
  localparam int HOUR_PER_DAY = 24;

  // request codes
  localparam logic [REQ_W-1:0] REQ_TICK       = 3'd0;
  localparam logic [REQ_W-1:0] REQ_REGISTER   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_UNREGISTER = 3'd2;
  localparam logic [REQ_W-1:0] REQ_SET        = 3'd3;
  localparam logic [REQ_W-1:0] REQ_GET        = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_DUPLICATE = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_BAD_KEY   = 3'd4;

  typedef struct packed {
    logic [MS_W-1:0]   millis;
    logic [SEC_W-1:0]  seconds;
    logic [MIN_W-1:0]  minutes;
    logic [HOUR_W-1:0] hours;
    logic [DAY_W-1:0]  days;
  } tod_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic execute;
  } ctb_cmd_t;

endpackage

`default_nettype wire

### hw/rtl/ctb_if.sv
// request and response channel interfaces of the countdown timer bank
`default_nettype none

interface ctb_req_if;
  import ctb_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [REQ_W-1:0]        req_type;
  logic [KEY_PORT_W-1:0]   timer_key;
  logic [VALUE_PORT_W-1:0] load_value;

  modport source (output valid, req_type, timer_key, load_value, input ready);
  modport sink   (input valid, req_type, timer_key, load_value, output ready);
endinterface

interface ctb_rsp_if;
  import ctb_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [STATUS_W-1:0]     status;
  logic [VALUE_PORT_W-1:0] read_value;
  logic [ACTIVE_W-1:0]     active_count;
  logic [MS_W-1:0]         millis;
  logic [SEC_W-1:0]        seconds;
  logic [MIN_W-1:0]        minutes;
  logic [HOUR_W-1:0]       hours;
  logic [DAY_W-1:0]        days;

  modport source (output valid, status, read_value, active_count, millis, seconds,
                  minutes, hours, days, input ready);
  modport sink   (input valid, status, read_value, active_count, millis, seconds,
                  minutes, hours, days, output ready);
endinterface

`default_nettype wire

### hw/rtl/countdown_timer_bank_with_clock.sv
// top level of the keyed countdown timer bank with time-of-day clock
// an accepted item is captured with its match vectors, then executed into the result registers
// one item in flight: input ready returns only once the controller's capture/execute pair is done;
//   execute waits while an earlier result is still held on the output
// reset (rst_n, synchronous, active low): all slots empty, count and clock at zero,
//   input ready and no result pending
`default_nettype none

module countdown_timer_bank_with_clock #(
  parameter int SLOTS       = ctb_pkg::SLOTS_DEF,
  parameter int KEY_WIDTH   = ctb_pkg::KEY_WIDTH_DEF,
  parameter int COUNT_WIDTH = ctb_pkg::COUNT_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  ctb_req_if.sink   in_req,
  ctb_rsp_if.source out_rsp
);
  import ctb_pkg::*;

  // commands from controller to datapath
  ctb_cmd_t cmd;
  tod_t     tod;

  // handshake control: one item in flight, result register on the output
  ctb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .cmd       (cmd)
  );

  // slot table, match vectors captured with the item, decode on execute
  ctb_datapath #(
    .SLOTS       (SLOTS),
    .KEY_WIDTH   (KEY_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .req_type_i     (in_req.req_type),
    .timer_key_i    (in_req.timer_key),
    .load_value_i   (in_req.load_value),
    .status_o       (out_rsp.status),
    .read_value_o   (out_rsp.read_value),
    .active_count_o (out_rsp.active_count),
    .tod_o          (tod)
  );

  // clock fields after the step
  assign out_rsp.millis  = tod.millis;
  assign out_rsp.seconds = tod.seconds;
  assign out_rsp.minutes = tod.minutes;
  assign out_rsp.hours   = tod.hours;
  assign out_rsp.days    = tod.days;

endmodule

`default_nettype wire

### hw/rtl/ctb_tod.sv
// millisecond time-of-day counter with day rollover
`default_nettype none

module ctb_tod (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          advance,
  output ctb_pkg::tod_t tod_o
);
  import ctb_pkg::*;

  localparam logic [MS_W-1:0]   MS_LAST   = MS_W'(MS_PER_SEC - 1);
  localparam logic [SEC_W-1:0]  SEC_LAST  = SEC_W'(SEC_PER_MIN - 1);
  localparam logic [MIN_W-1:0]  MIN_LAST  = MIN_W'(MIN_PER_HOUR - 1);
  localparam logic [HOUR_W-1:0] HOUR_LAST = HOUR_W'(HOUR_PER_DAY - 1);

  tod_t tod_r, tod_nxt;

  always_comb begin
    tod_nxt = tod_r;
    if (tod_r.millis != MS_LAST) begin
      tod_nxt.millis = tod_r.millis + MS_W'(1);
    end else begin
      tod_nxt.millis = '0;
      if (tod_r.seconds != SEC_LAST) begin
        tod_nxt.seconds = tod_r.seconds + SEC_W'(1);
      end else begin
        tod_nxt.seconds = '0;
        if (tod_r.minutes != MIN_LAST) begin
          tod_nxt.minutes = tod_r.minutes + MIN_W'(1);
        end else begin
          tod_nxt.minutes = '0;
          if (tod_r.hours != HOUR_LAST) begin
            tod_nxt.hours = tod_r.hours + HOUR_W'(1);
          end else begin
            tod_nxt.hours = '0;
            tod_nxt.days  = tod_r.days + DAY_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tod_r <= '0;
    end else if (advance) begin
      tod_r <= tod_nxt;
    end
  end

  assign tod_o = tod_r;

endmodule

`default_nettype wire

### hw/rtl/ctb_ctrl.sv
// capture / execute controller and response valid of the timer bank
`default_nettype none

module ctb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output ctb_pkg::ctb_cmd_t cmd
);
  import ctb_pkg::*;

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t state_r;
  logic   in_ready_r;
  logic   out_valid_r;
  logic   capture;
  logic   execute;

  assign capture = in_valid && in_ready_r;
  // result slot must be free before the work lands in it
  assign execute = (state_r == S_EXEC) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_ready_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (capture) begin
            state_r    <= S_EXEC;
            in_ready_r <= 1'b0;
          end
        end
        S_EXEC: begin
          if (execute) begin
            state_r     <= S_IDLE;
            in_ready_r  <= 1'b1;
            out_valid_r <= 1'b1;
          end
        end
        default: begin
          state_r    <= S_IDLE;
          in_ready_r <= 1'b1;
        end
      endcase
    end
  end

  assign in_ready    = in_ready_r;
  assign out_valid   = out_valid_r;
  assign cmd.capture = capture;
  assign cmd.execute = execute;

endmodule

`default_nettype wire

### hw/rtl/ctb_datapath.sv
// timer slot table, key match, request decode and result registers
`default_nettype none

module ctb_datapath #(
  parameter int SLOTS       = ctb_pkg::SLOTS_DEF,
  parameter int KEY_WIDTH   = ctb_pkg::KEY_WIDTH_DEF,
  parameter int COUNT_WIDTH = ctb_pkg::COUNT_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  ctb_pkg::ctb_cmd_t                cmd,
  input  logic [ctb_pkg::REQ_W-1:0]        req_type_i,
  input  logic [ctb_pkg::KEY_PORT_W-1:0]   timer_key_i,
  input  logic [ctb_pkg::VALUE_PORT_W-1:0] load_value_i,
  output logic [ctb_pkg::STATUS_W-1:0]     status_o,
  output logic [ctb_pkg::VALUE_PORT_W-1:0] read_value_o,
  output logic [ctb_pkg::ACTIVE_W-1:0]     active_count_o,
  output ctb_pkg::tod_t                    tod_o
);
  import ctb_pkg::*;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int TOT_W = $clog2(SLOTS + 1);

  // slot table: valid bit per slot, key and count as payload
  logic [SLOTS-1:0]       valid_r;
  logic [KEY_WIDTH-1:0]   key_r [SLOTS];
  logic [COUNT_WIDTH-1:0] cnt_r [SLOTS];
  logic [TOT_W-1:0]       total_r, total_nxt;

  // captured request and match vectors
  logic [REQ_W-1:0]       req_r;
  logic [KEY_WIDTH-1:0]   req_key_r;
  logic [COUNT_WIDTH-1:0] req_val_r;
  logic [SLOTS-1:0]       hit_r, free_r;
  logic [KEY_WIDTH-1:0]   in_key;
  logic [SLOTS-1:0]       hit_c;

  // execute decode
  logic                    hit_any, free_any;
  logic [IDX_W-1:0]        hit_idx, free_idx;
  logic [STATUS_W-1:0]     status_c;
  logic [VALUE_PORT_W-1:0] rd_c;
  logic                    do_tick, do_new, do_clear, do_set;

  logic [STATUS_W-1:0]     status_r;
  logic [VALUE_PORT_W-1:0] rd_r;

  assign in_key = KEY_WIDTH'(timer_key_i);

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      hit_c[i] = valid_r[i] && (key_r[i] == in_key);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r     <= req_type_i;
      req_key_r <= in_key;
      req_val_r <= COUNT_WIDTH'(load_value_i);
      hit_r     <= hit_c;
      free_r    <= ~valid_r;
    end
  end

  // highest index wins
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (hit_r[i]) begin
        hit_idx = IDX_W'(i);
      end
      if (free_r[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  assign hit_any  = |hit_r;
  assign free_any = |free_r;

  always_comb begin
    status_c  = STAT_OK;
    rd_c      = '0;
    do_tick   = 1'b0;
    do_new    = 1'b0;
    do_clear  = 1'b0;
    do_set    = 1'b0;
    total_nxt = total_r;
    case (req_r)
      REQ_TICK: begin
        do_tick = 1'b1;
      end
      REQ_REGISTER, REQ_UNREGISTER, REQ_SET, REQ_GET: begin
        if (req_key_r == '0) begin
          status_c = STAT_BAD_KEY;
        end else if (req_r == REQ_REGISTER) begin
          if (hit_any) begin
            status_c = STAT_DUPLICATE;
          end else if (!free_any) begin
            status_c = STAT_FULL;
          end else begin
            do_new    = 1'b1;
            total_nxt = total_r + TOT_W'(1);
          end
        end else if (!hit_any) begin
          status_c = STAT_NOT_FOUND;
        end else if (req_r == REQ_UNREGISTER) begin
          do_clear = 1'b1;
          if (total_r != '0) begin
            total_nxt = total_r - TOT_W'(1);
          end
        end else if (req_r == REQ_SET) begin
          do_set = 1'b1;
        end else begin
          rd_c = VALUE_PORT_W'(cnt_r[hit_idx]);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      total_r <= '0;
    end else if (cmd.execute) begin
      total_r <= total_nxt;
      if (do_new) begin
        valid_r[free_idx] <= 1'b1;
      end
      if (do_clear) begin
        valid_r[hit_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      status_r <= status_c;
      rd_r     <= rd_c;
      for (int i = 0; i < SLOTS; i++) begin
        if (do_tick && valid_r[i] && (cnt_r[i] != '0)) begin
          cnt_r[i] <= cnt_r[i] - COUNT_WIDTH'(1);
        end
        if (do_new && (free_idx == IDX_W'(i))) begin
          key_r[i] <= req_key_r;
          cnt_r[i] <= req_val_r;
        end
        if (do_set && (hit_idx == IDX_W'(i))) begin
          cnt_r[i] <= req_val_r;
        end
      end
    end
  end

  ctb_tod u_tod (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (cmd.execute && do_tick),
    .tod_o   (tod_o)
  );

  // state only moves on execute, which waits for a free result slot,
  // so count and clock registers stand for the pending result
  assign status_o       = status_r;
  assign read_value_o   = rd_r;
  assign active_count_o = ACTIVE_W'(total_r);

endmodule

`default_nettype wire
